FILE: sv/monte_carlo_pi_hit_counter_core_macros.svh
// Assertion macros shared by the Monte Carlo pi hit counter RTL.
`ifndef MONTE_CARLO_PI_HIT_COUNTER_CORE_MACROS_SVH
`define MONTE_CARLO_PI_HIT_COUNTER_CORE_MACROS_SVH

// Check a consequence in the same cycle as its antecedent.
`define MCPI_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Check a consequence in the cycle after its antecedent.
`define MCPI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/mcpi_pkg.sv
// Types, constants and helper functions of the Monte Carlo pi hit counter.
package mcpi_pkg;

    // Field widths
    localparam int TOTAL_W    = 40;
    localparam int RANKS_W    = 9;
    localparam int RIDX_W     = 8;
    localparam int RUN_W      = 31;
    localparam int OUT_W      = 40;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 40;
    localparam int FRAC_W     = 53;
    localparam int SQ_W       = 2 * FRAC_W;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RANKS    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RANK_IDX = 2'd2;

    // Register reset values
    localparam logic [TOTAL_W-1:0] DEFAULT_TOTAL = 40'd100000000;
    localparam logic [RANKS_W-1:0] DEFAULT_RANKS = 9'd1;

    // Seed mixing and output scrambling constants
    localparam logic [63:0] SEED_BASE = 64'h243f6a8885a308d3;
    localparam logic [63:0] SEED_RANK = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] SEED_RUN  = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] OUT_MULT  = 64'd2685821657736338717;

    // Restoring divider runs one quotient bit per cycle
    localparam int DIV_STEPS = TOTAL_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    // Sample pipeline stages from issue to hit decision
    localparam int PIPE_DEPTH = 10;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEED_A,
        ST_SEED_B,
        ST_SEED_C,
        ST_DIV,
        ST_RUN,
        ST_DRAIN,
        ST_DONE
    } t_state;

    // One xorshift64 state update with shifts 12, 25, 27
    function automatic logic [63:0] f_xs_step(input logic [63:0] w);
        logic [63:0] a;
        logic [63:0] b;
        a = w ^ (w >> 12);
        b = a ^ (a << 25);
        return b ^ (b >> 27);
    endfunction

    // 32 x 32 product with full 64-bit result
    function automatic logic [63:0] f_mul32(input logic [31:0] a, input logic [31:0] b);
        return 64'(a) * 64'(b);
    endfunction

endpackage

FILE: sv/monte_carlo_pi_hit_counter_core.sv
// Top level of the Monte Carlo pi hit counter: job control, divider and sample pipeline.
//
//  channel  | handshake                    | payload
//  ---------+------------------------------+----------------------------------
//  job in   | i_valid / o_ready            | i_run_number
//  result   | o_valid / i_ready            | o_hit_count, o_samples_done
//  config   | i_cfg_valid / o_cfg_ready    | i_cfg_index, i_cfg_data
//
// From one acceptance to the next, a job passes through 3 seed states, the one-bit-per-cycle
// share divider, the samples (two xorshift steps chained per cycle), the pipeline drain, the
// result load and idle; with a zero share no sample is issued.
// Reset is synchronous and brings the state, configuration, counters and valid flags to their defaults.
// The result waits in its output register; a new job is taken meanwhile and
// holds in its final state until the previous result has been taken.
`include "monte_carlo_pi_hit_counter_core_macros.svh"

module monte_carlo_pi_hit_counter_core #(
    parameter int MAX_RANKS  = 256,
    parameter int COUNT_BITS = 40
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [mcpi_pkg::RUN_W-1:0]        i_run_number,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [mcpi_pkg::OUT_W-1:0]        o_hit_count,
    output logic [mcpi_pkg::OUT_W-1:0]        o_samples_done,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [mcpi_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [mcpi_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import mcpi_pkg::*;

    // Control
    t_state                  r_state, n_state;
    logic                    s_accept;
    logic                    s_issue;
    logic                    s_out_load;

    // Configuration
    logic [TOTAL_W-1:0]      r_total;
    logic [RANKS_W-1:0]      r_ranks;
    logic [RIDX_W-1:0]       r_rank_idx;
    logic [TOTAL_W-1:0]      s_total_eff;
    logic [RANKS_W-1:0]      s_ranks_nz;
    logic [RANKS_W-1:0]      s_ranks;
    logic                    s_last_rank;

    // Seed and divider
    logic [RUN_W-1:0]        r_run;
    logic [63:0]             r_mul_a;
    logic [63:0]             r_mul_b;
    logic [31:0]             r_mul_c;
    logic [TOTAL_W-1:0]      r_div_q;
    logic [RANKS_W-1:0]      r_div_r;
    logic [DIV_CNT_W-1:0]    r_div_cnt;
    logic [RANKS_W:0]        s_div_t;
    logic [RANKS_W:0]        s_div_sub;
    logic                    s_div_ge;
    logic [TOTAL_W-1:0]      s_share;
    logic [TOTAL_W-1:0]      r_share;
    logic [TOTAL_W-1:0]      r_left;

    // Generator
    logic [63:0]             r_gen;
    logic [63:0]             s_w1;
    logic [63:0]             s_w2;

    // Sample pipeline, lane 0 is x and lane 1 is y
    logic [PIPE_DEPTH-1:0]   r_vld;
    logic [63:0]             r_p1_w   [2];
    logic [63:0]             r_p2_ll  [2];
    logic [31:0]             r_p2_wl  [2];
    logic [31:0]             r_p2_wh  [2];
    logic [63:0]             r_p3_ll  [2];
    logic [31:0]             r_p3_wh  [2];
    logic [31:0]             r_p3_b   [2];
    logic [63:0]             r_p4_ll  [2];
    logic [31:0]             r_p4_mid [2];
    logic [63:0]             s_p5_out [2];
    logic [FRAC_W-1:0]       r_p5_x   [2];
    logic [63:0]             r_p6_xl2 [2];
    logic [FRAC_W-1:0]       r_p6_x   [2];
    logic [63:0]             r_p7_xl2 [2];
    logic [FRAC_W-1:0]       r_p7_xm  [2];
    logic [FRAC_W-33:0]      r_p7_xh  [2];
    logic [63:0]             r_p8_xl2 [2];
    logic [FRAC_W-1:0]       r_p8_xm  [2];
    logic [2*(FRAC_W-32)-1:0] r_p8_xh2 [2];
    logic [SQ_W-1:0]         r_p9_sq  [2];
    logic                    r_p10_hit;

    // Hit counter and result
    logic [COUNT_BITS-1:0]   r_hit;
    logic [63:0]             s_hit_ext;
    logic                    r_out_valid;
    logic [OUT_W-1:0]        r_out_hit;
    logic [OUT_W-1:0]        r_out_done;

    assign o_ready        = (r_state == ST_IDLE);
    assign o_cfg_ready    = 1'b1;
    assign o_valid        = r_out_valid;
    assign o_hit_count    = r_out_hit;
    assign o_samples_done = r_out_done;
    assign s_accept       = i_valid && o_ready;

    // Resolve the effective sample total and rank count
    always_comb begin
        s_total_eff = (r_total == '0) ? DEFAULT_TOTAL : r_total;
        s_ranks_nz  = (r_ranks == '0) ? DEFAULT_RANKS : r_ranks;
        if (17'(s_ranks_nz) > 17'(MAX_RANKS)) begin
            s_ranks = RANKS_W'(MAX_RANKS);
        end else begin
            s_ranks = s_ranks_nz;
        end
        s_last_rank = ({1'b0, r_rank_idx} == (s_ranks - 9'd1));
    end

    // Advance the restoring divider by one quotient bit
    always_comb begin
        s_div_t   = {r_div_r, r_div_q[TOTAL_W-1]};
        s_div_sub = s_div_t - {1'b0, s_ranks};
        s_div_ge  = (s_div_t >= {1'b0, s_ranks});
        s_share   = r_div_q + (s_last_rank ? TOTAL_W'(r_div_r) : '0);
    end

    // Two chained generator steps give the x and y words of one sample
    always_comb begin
        s_w1 = f_xs_step(r_gen);
        s_w2 = f_xs_step(s_w1);
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and control strobes
    always_comb begin
        n_state    = r_state;
        s_issue    = 1'b0;
        s_out_load = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = ST_SEED_A;
                end
            end
            ST_SEED_A: n_state = ST_SEED_B;
            ST_SEED_B: n_state = ST_SEED_C;
            ST_SEED_C: n_state = ST_DIV;
            ST_DIV: begin
                if (r_div_cnt == '0) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (r_left == '0) begin
                    n_state = ST_DRAIN;
                end else begin
                    s_issue = 1'b1;
                end
            end
            ST_DRAIN: begin
                if (r_vld == '0) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_ready) begin
                    s_out_load = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total    <= DEFAULT_TOTAL;
            r_ranks    <= DEFAULT_RANKS;
            r_rank_idx <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_TOTAL:    r_total    <= i_cfg_data[TOTAL_W-1:0];
                CFG_RANKS:    r_ranks    <= i_cfg_data[RANKS_W-1:0];
                CFG_RANK_IDX: r_rank_idx <= i_cfg_data[RIDX_W-1:0];
                default: ;
            endcase
        end
    end

    // Job datapath: seed, divide, issue and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left  <= '0;
            r_share <= '0;
            r_hit   <= '0;
            r_vld   <= '0;
        end else begin
            r_vld <= {r_vld[PIPE_DEPTH-2:0], s_issue};
            if (s_accept) begin
                r_run     <= i_run_number;
                r_div_q   <= s_total_eff;
                r_div_r   <= '0;
                r_div_cnt <= DIV_CNT_W'(DIV_STEPS);
                r_hit     <= '0;
            end
            // Mix rank and run into the seed over the three seed states
            if (r_state == ST_SEED_A) begin
                r_mul_a <= 64'(({1'b0, r_rank_idx} + 9'd1)) * SEED_RANK;
                r_mul_b <= f_mul32({1'b0, r_run}, SEED_RUN[31:0]);
            end
            if (r_state == ST_SEED_B) begin
                r_mul_c <= 32'(f_mul32({1'b0, r_run}, SEED_RUN[63:32]));
            end
            if (r_state == ST_SEED_C) begin
                r_gen <= SEED_BASE ^ r_mul_a ^ (r_mul_b + {r_mul_c, 32'b0});
            end
            // Divide, then load the share
            if (r_state == ST_DIV) begin
                if (r_div_cnt != '0) begin
                    r_div_q   <= {r_div_q[TOTAL_W-2:0], s_div_ge};
                    r_div_r   <= s_div_ge ? s_div_sub[RANKS_W-1:0] : s_div_t[RANKS_W-1:0];
                    r_div_cnt <= r_div_cnt - 1'b1;
                end else begin
                    r_share <= s_share;
                    r_left  <= s_share;
                end
            end
            // Issue one sample
            if (s_issue) begin
                r_gen     <= s_w2;
                r_p1_w[0] <= s_w1;
                r_p1_w[1] <= s_w2;
                r_left    <= r_left - 1'b1;
            end
            // Count hits, saturating
            if (r_vld[PIPE_DEPTH-1] && r_p10_hit && (r_hit != '1)) begin
                r_hit <= r_hit + 1'b1;
            end
        end
    end

    // Combine the output scrambler partial products
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            s_p5_out[l] = {r_p4_ll[l][63:32] + r_p4_mid[l], r_p4_ll[l][31:0]};
        end
    end

    // Sample pipeline stages, no stall inside
    always_ff @(posedge i_clk) begin
        for (int l = 0; l < 2; l++) begin
            r_p2_ll[l]  <= f_mul32(r_p1_w[l][31:0], OUT_MULT[31:0]);
            r_p2_wl[l]  <= r_p1_w[l][31:0];
            r_p2_wh[l]  <= r_p1_w[l][63:32];
            r_p3_ll[l]  <= r_p2_ll[l];
            r_p3_wh[l]  <= r_p2_wh[l];
            r_p3_b[l]   <= 32'(f_mul32(r_p2_wl[l], OUT_MULT[63:32]));
            r_p4_ll[l]  <= r_p3_ll[l];
            r_p4_mid[l] <= r_p3_b[l] + 32'(f_mul32(r_p3_wh[l], OUT_MULT[31:0]));
            r_p5_x[l]   <= s_p5_out[l][63:64-FRAC_W];
            r_p6_xl2[l] <= f_mul32(r_p5_x[l][31:0], r_p5_x[l][31:0]);
            r_p6_x[l]   <= r_p5_x[l];
            r_p7_xl2[l] <= r_p6_xl2[l];
            r_p7_xm[l]  <= FRAC_W'(f_mul32(32'(r_p6_x[l][FRAC_W-1:32]), r_p6_x[l][31:0]));
            r_p7_xh[l]  <= r_p6_x[l][FRAC_W-1:32];
            r_p8_xl2[l] <= r_p7_xl2[l];
            r_p8_xm[l]  <= r_p7_xm[l];
            r_p8_xh2[l] <= (2*(FRAC_W-32))'(f_mul32(32'(r_p7_xh[l]), 32'(r_p7_xh[l])));
            r_p9_sq[l]  <= {r_p8_xh2[l], 64'b0} + (SQ_W'(r_p8_xm[l]) << 33)
                         + SQ_W'(r_p8_xl2[l]);
        end
        r_p10_hit <= ((SQ_W+1)'(r_p9_sq[0]) + (SQ_W+1)'(r_p9_sq[1]))
                  <= ((SQ_W+1)'(1) << SQ_W);
    end

    // Output register
    assign s_hit_ext = 64'(r_hit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_out_load) begin
            r_out_valid <= 1'b1;
            r_out_hit   <= s_hit_ext[OUT_W-1:0];
            r_out_done  <= r_share;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    `MCPI_ASSERT_NOW(a_idle_empty, r_state == ST_IDLE, r_vld == '0, "pipeline busy while idle")
    `MCPI_ASSERT_NEXT(a_issue_run, r_state != ST_RUN, !r_vld[0], "sample issued outside run")
    `MCPI_ASSERT_NOW(a_hits_le_share, r_state == ST_DONE, 64'(r_hit) <= 64'(r_share), "hits exceed samples")
    `MCPI_ASSERT_NEXT(a_done_loads, s_out_load, r_out_valid, "result not loaded")
    `MCPI_ASSERT_NOW(a_rem_lt_div, r_state == ST_DIV, r_div_r < s_ranks, "remainder not below divisor")

endmodule

FILE: verif/monte_carlo_pi_hit_counter_core_test.sv
// Self-checking testbench for the Monte Carlo pi hit counter core.
module monte_carlo_pi_hit_counter_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import mcpi_pkg::*;

    localparam int MAX_RANKS   = 256;
    localparam int COUNT_BITS  = 40;
    localparam int STALL_LIMIT = 2_000_000;
    localparam int HOLD_CYCLES = 600;
    localparam int TAIL_CYCLES = 200;
    localparam int REPORT_MAX  = 10;
    localparam int GROUPS      = 8;
    localparam int GROUP_RUNS  = 13;

    // Index with no register behind it
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef struct packed {
        logic [OUT_W-1:0] hits;
        logic [OUT_W-1:0] drawn;
    } t_tally;

    // Register copy, hit count prediction and queue of expected tallies
    class hit_count_board;
        logic [TOTAL_W-1:0] total_reg;
        logic [RANKS_W-1:0] ranks_reg;
        logic [RIDX_W-1:0]  rank_idx_reg;
        t_tally             expected_tallies[$];
        int unsigned        mismatches;
        int unsigned        jobs;
        int unsigned        checked;
        longint unsigned    samples;

        function new();
            total_reg    = DEFAULT_TOTAL;
            ranks_reg    = DEFAULT_RANKS;
            rank_idx_reg = '0;
            mismatches   = 0;
            jobs         = 0;
            checked      = 0;
            samples      = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_TOTAL:    total_reg    = data[TOTAL_W-1:0];
                CFG_RANKS:    ranks_reg    = data[RANKS_W-1:0];
                CFG_RANK_IDX: rank_idx_reg = data[RIDX_W-1:0];
                default: ;
            endcase
        endfunction

        // Advance the xorshift word and return the top bits of its scrambled output
        function logic [FRAC_W-1:0] draw_fraction(inout logic [63:0] w);
            logic [63:0] scrambled;
            w = w ^ (w >> 12);
            w = w ^ (w << 25);
            w = w ^ (w >> 27);
            scrambled = w * OUT_MULT;
            return scrambled[63:64-FRAC_W];
        endfunction

        // Draw this rank's share of samples for one run and count quarter-circle hits
        function t_tally count_hits(logic [RUN_W-1:0] run);
            logic [63:0]           total;
            logic [63:0]           ranks;
            logic [63:0]           share;
            logic [63:0]           w;
            logic [SQ_W+1:0]       xx;
            logic [SQ_W+1:0]       yy;
            logic [COUNT_BITS-1:0] hit_ctr;
            longint unsigned       n;
            t_tally                t;
            total = (total_reg == '0) ? 64'(DEFAULT_TOTAL) : 64'(total_reg);
            ranks = (ranks_reg == '0) ? 64'd1 : 64'(ranks_reg);
            if (ranks > MAX_RANKS)
                ranks = MAX_RANKS;
            share = total / ranks;
            if (64'(rank_idx_reg) == ranks - 1)
                share += total % ranks;
            w = SEED_BASE ^ ((64'(rank_idx_reg) + 64'd1) * SEED_RANK) ^ (64'(run) * SEED_RUN);
            hit_ctr = '0;
            for (n = 0; n < share; n++) begin
                xx = draw_fraction(w);
                yy = draw_fraction(w);
                if (xx * xx + yy * yy <= ((SQ_W+2)'(1) << SQ_W) && hit_ctr != '1)
                    hit_ctr++;
            end
            t.hits  = OUT_W'(hit_ctr);
            t.drawn = OUT_W'(share);
            return t;
        endfunction

        function void note_run(logic [RUN_W-1:0] run);
            t_tally t;
            t = count_hits(run);
            expected_tallies.push_back(t);
            jobs++;
            samples += t.drawn;
        endfunction

        function void flag(string what);
            mismatches++;
            if (mismatches <= REPORT_MAX)
                $display("ERROR: %s", what);
        endfunction

        function void check_tally(logic [OUT_W-1:0] hits, logic [OUT_W-1:0] drawn);
            t_tally want;
            if (expected_tallies.size() == 0) begin
                flag($sformatf("result with no job pending: hits %0d samples %0d", hits, drawn));
                return;
            end
            want = expected_tallies.pop_front();
            checked++;
            if (hits !== want.hits)
                flag($sformatf("result %0d hit_count: expected %0d, got %0d",
                               checked, want.hits, hits));
            if (drawn !== want.drawn)
                flag($sformatf("result %0d samples_done: expected %0d, got %0d",
                               checked, want.drawn, drawn));
        endfunction

        function int unsigned pending();
            return expected_tallies.size();
        endfunction
    endclass

    logic                  i_clk        = 1'b0;
    logic                  i_rst_n      = 1'b0;
    logic                  i_valid      = 1'b0;
    logic                  o_ready;
    logic [RUN_W-1:0]      i_run_number = '0;
    logic                  o_valid;
    logic                  i_ready      = 1'b0;
    logic [OUT_W-1:0]      o_hit_count;
    logic [OUT_W-1:0]      o_samples_done;
    logic                  i_cfg_valid  = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index  = CFG_TOTAL;
    logic [CFG_DATA_W-1:0] i_cfg_data   = '0;

    hit_count_board board = new();

    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    bit          hold_request   = 1'b0;
    int unsigned idle_cycles    = 0;
    int unsigned settings_run   = 0;

    monte_carlo_pi_hit_counter_core #(
        .MAX_RANKS  (MAX_RANKS),
        .COUNT_BITS (COUNT_BITS)
    ) dut (.*);

    // Free-running clock, 10 ns period
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Count cycles without any transaction on any channel
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        wait (idle_cycles >= STALL_LIMIT);
        $display("timeout: no transaction for %0d cycles, %0d results outstanding",
                 STALL_LIMIT, board.pending());
        $display("monte_carlo_pi_hit_counter_core: mismatch");
        $finish;
    end

    // Result side: check each transaction, then stall at random or hold off on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (o_valid && i_ready)
                board.check_tally(o_hit_count, o_samples_done);
            if (hold_request) begin
                hold_request = 1'b0;
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Write one register; valid stays high for a following write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        board.set_reg(idx, data);
    endtask

    // Program all three registers, with junk above the used bits of the rank count and rank index
    task automatic apply_setting(input logic [TOTAL_W-1:0] total, input logic [RANKS_W-1:0] ranks,
                                 input logic [RIDX_W-1:0] ridx, input bit touch_spare);
        logic [CFG_DATA_W-1:0] data;
        write_reg(CFG_TOTAL, CFG_DATA_W'(total));
        data = CFG_DATA_W'({$urandom(), $urandom()});
        data[RANKS_W-1:0] = ranks;
        write_reg(CFG_RANKS, data);
        data = CFG_DATA_W'({$urandom(), $urandom()});
        data[RIDX_W-1:0] = ridx;
        write_reg(CFG_RANK_IDX, data);
        if (touch_spare)
            write_reg(CFG_SPARE, CFG_DATA_W'({$urandom(), $urandom()}));
        i_cfg_valid <= 1'b0;
        settings_run++;
    endtask

    // Random setting with a small share per rank
    task automatic pick_setting();
        logic [RANKS_W-1:0] ranks;
        logic [RIDX_W-1:0]  ridx;
        int unsigned        eff;
        logic [TOTAL_W-1:0] total;
        ranks = $urandom_range(1) ? RANKS_W'($urandom_range(1, 8)) : RANKS_W'($urandom_range(0, 511));
        eff = (ranks == 0) ? 1 : ((ranks > MAX_RANKS) ? MAX_RANKS : ranks);
        ridx = $urandom_range(1) ? RIDX_W'(eff - 1) : RIDX_W'($urandom_range(0, 255));
        total = TOTAL_W'(eff * $urandom_range(0, 40) + $urandom_range(0, eff - 1));
        if (total == '0)
            total = 1;
        apply_setting(total, ranks, ridx, $urandom_range(3) == 0);
    endtask

    function automatic logic [RUN_W-1:0] pick_run();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return RUN_W'($urandom());
        endcase
    endfunction

    // Offer one run after a random idle stretch and wait for its transaction
    task automatic offer_run(input logic [RUN_W-1:0] run);
        int gap;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_run_number <= run;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        board.note_run(run);
    endtask

    // Drop valid and wait until every expected result has been taken
    task automatic finish_batch();
        i_valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Single sample per job, run number extremes and alternating bits
        apply_setting(40'd1, 9'd1, 8'd0, 1'b1);
        offer_run('0);
        offer_run(31'd1);
        offer_run('1);
        offer_run(31'h2AAAAAAA);
        offer_run(31'h55555555);
        finish_batch();

        // Zero rank count reads as one
        apply_setting(40'd7, 9'd0, 8'd0, 1'b0);
        offer_run(31'd12345);
        offer_run('0);
        finish_batch();

        // Oversized rank count clamps; last rank takes the remainder
        apply_setting(40'd1000, 9'd511, 8'd255, 1'b0);
        offer_run(31'd1);
        offer_run('1);
        finish_batch();

        apply_setting(40'd1000, 9'd256, 8'd3, 1'b0);
        offer_run(31'd77);
        finish_batch();

        // Rank beyond the last one gets the even share only
        apply_setting(40'd37, 9'd5, 8'd200, 1'b0);
        offer_run(31'd99);
        finish_batch();

        apply_setting(40'd100, 9'd3, 8'd2, 1'b0);
        offer_run(31'd5);
        offer_run(31'd6);
        finish_batch();

        // Largest total is written, then zero total falls back to the default count
        write_reg(CFG_TOTAL, CFG_DATA_W'({TOTAL_W{1'b1}}));
        apply_setting(40'd0, 9'd256, 8'd0, 1'b0);
        offer_run(31'd1);
        finish_batch();

        // Random settings and runs under each pacing mode
        for (int g = 0; g < GROUPS; g++) begin
            case (g / 2)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
                default: begin send_idle_pct = 12; recv_stall_pct = 12; end
            endcase
            pick_setting();
            if (g == 0 || g == 4)
                hold_request = 1'b1;
            for (int k = 0; k < GROUP_RUNS; k++)
                offer_run(pick_run());
            finish_batch();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("ran %0d jobs under %0d register settings, %0d samples drawn, %0d results checked",
                 board.jobs, settings_run, board.samples, board.checked);
        $display("pacing: free flow, sender gaps, receiver stalls, both, and long result hold-offs");
        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("monte_carlo_pi_hit_counter_core: match");
        end else begin
            $display("%0d field mismatches", board.mismatches);
            $display("monte_carlo_pi_hit_counter_core: mismatch");
        end
        $finish;
    end

endmodule
